// ===== sv/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg: shared types and codes for the positional list
// Holds request and status codes and the control word that the cells receive.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef logic signed [VAL_W-1:0] t_value;

    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic [POS_W-1:0] pos;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== sv/positional_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top: ordered list with insert/delete at index
// Input channel (i_in_valid / o_in_ready) carries one request: i_req_type
// selects insert or delete, i_position the list index, i_item_value the
// value to insert. Output channel (o_out_valid / i_out_ready) returns one
// result per request: o_status, o_removed_value and o_list_length.
// The list is a row of CAPACITY cells; every cell compares its index with the
// request position and shifts in the cycle its request transfers, so a result
// is registered on the output channel in the cycle after its transfer.
// Throughput: one request per cycle while the receiver keeps taking results.
// The output register holds a result until it is taken; a new request is
// taken in the same cycle the pending result transfers.
// When the receiver stalls with a result pending, o_in_ready drops.
// Reset empties the list (length zero) and clears the pending result; slot
// contents are not cleared since only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_top
    import pli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_req_type,
    input  wire logic [POS_W-1:0]    i_position,
    input  wire logic signed [31:0]  i_item_value,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [31:0]       o_removed_value,
    output logic [LEN_W-1:0]         o_list_length
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    t_value              r_removed;
    t_value              n_removed;

    logic                in_xfer;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic                is_full;
    t_cell_ctrl          cell_ctrl;

    t_value              cell_value [CAPACITY];
    t_value              cell_tap   [CAPACITY];
    t_value              tap_or;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign pos_ext    = CMP_W'(i_position);
    assign cnt_ext    = CMP_W'(r_count);
    assign is_full    = (r_count == CW'(CAPACITY));

    always_comb begin
        tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

    always_comb begin
        n_status  = ST_DONE;
        n_removed = '0;
        n_count   = r_count;
        unique case (i_req_type)
            REQ_INSERT: begin
                priority if (is_full) begin
                    n_status = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    n_status = ST_INVALID;
                end else begin
                    n_status = ST_DONE;
                    n_count  = r_count + CW'(1);
                end
            end
            REQ_DELETE: begin
                if ((r_count == '0) || (pos_ext >= cnt_ext)) begin
                    n_status = ST_INVALID;
                end else begin
                    n_status  = ST_DONE;
                    n_removed = tap_or;
                    n_count   = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    always_comb begin
        cell_ctrl.pos    = i_position;
        cell_ctrl.ins_en = in_xfer && (i_req_type == REQ_INSERT) && (n_status == ST_DONE);
        cell_ctrl.del_en = in_xfer && (i_req_type == REQ_DELETE) && (n_status == ST_DONE);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_value left_v;
        t_value right_v;
        if (g == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_value[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_mid_r
            assign right_v = cell_value[g+1];
        end
        pli_cell #(
            .INDEX (g),
            .CMP_W (CMP_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_new_value   (i_item_value),
            .i_left_value  (left_v),
            .i_right_value (right_v),
            .o_value       (cell_value[g]),
            .o_tap         (cell_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_list_length   = LEN_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_req_type == REQ_INSERT) && (n_status == ST_DONE))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (n_status != ST_DONE)) |=> (r_count == $past(r_count)))
        else $error("rejected request changed the length");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_DONE)) |-> (r_removed == '0))
        else $error("rejected request returned a value");

    a_full_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (n_status == ST_FULL)) |-> (is_full && (i_req_type == REQ_INSERT)))
        else $error("full status without a full list");

endmodule

`default_nettype wire

// ===== sv/pli_cell.sv =====
// ----------------------------------------------------------------------------
// pli_cell: one slot of the positional list
// Holds one value and moves it toward or away from its neighbors on a
// committed insert or delete, based on its index against the request position.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_cell
    import pli_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = 9
) (
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_value     i_new_value,
    input  wire t_value     i_left_value,
    input  wire t_value     i_right_value,
    output t_value          o_value,
    output t_value          o_tap
);

    localparam logic [CMP_W-1:0] IdxC = CMP_W'(INDEX);

    logic [CMP_W-1:0] pos_ext;
    t_value           r_value;
    t_value           n_value;

    assign pos_ext = CMP_W'(i_ctrl.pos);

    always_comb begin
        n_value = r_value;
        priority if (i_ctrl.ins_en && (IdxC > pos_ext)) begin
            n_value = i_left_value;
        end else if (i_ctrl.ins_en && (IdxC == pos_ext)) begin
            n_value = i_new_value;
        end else if (i_ctrl.del_en && (IdxC >= pos_ext)) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = (IdxC == pos_ext) ? r_value : '0;

endmodule

`default_nettype wire
